FILE: hw/rtl/dtt_pkg.sv
package dtt_pkg;

    localparam int MaxDet    = 16;
    localparam int MaxTrk    = 16;
    localparam int WinLen    = 20;
    localparam int DetIdxW   = $clog2(MaxDet);
    localparam int TrkIdxW   = $clog2(MaxTrk);
    localparam int DetCntW   = $clog2(MaxDet + 1);
    localparam int TrkCntW   = $clog2(MaxTrk + 1);
    localparam int CoordW    = 10;
    localparam int IdentW    = 16;
    localparam int SeenW     = 5;
    localparam int CfgIdxW   = 8;
    localparam int DistW     = 2 * CoordW + 1;

    localparam logic [CfgIdxW-1:0] REG_DEDUP = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_MATCH = 8'd1;

    localparam logic [CoordW-1:0] DEDUP_RESET = 10'd20;
    localparam logic [CoordW-1:0] MATCH_RESET = 10'd10;

    typedef struct packed {
        logic [CoordW-1:0] det_x;
        logic [CoordW-1:0] det_y;
        logic              has_detection;
        logic              end_of_frame;
    } det_beat_t;

    typedef struct packed {
        logic              track_valid;
        logic [IdentW-1:0] track_ident;
        logic [CoordW-1:0] track_x;
        logic [CoordW-1:0] track_y;
        logic [SeenW-1:0]  seen_count;
        logic              dropped;
        logic              last_result;
    } trk_beat_t;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [CoordW-1:0]  data;
    } cfg_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEDUP,
        ST_MATCH,
        ST_SHIFT,
        ST_APPEND,
        ST_EMIT,
        ST_EMIT_WAIT
    } state_t;

    function automatic logic [SeenW-1:0] sat_ones(input logic [WinLen-1:0] w);
        logic [$clog2(WinLen+1)-1:0] n;
        n = '0;
        for (int i = 0; i < WinLen; i++) begin
            n = n + {{($clog2(WinLen+1)-1){1'b0}}, w[i]};
        end
        if (32'(n) > 31) begin
            return SeenW'(31);
        end
        return SeenW'(n);
    endfunction

endpackage

FILE: hw/rtl/dtt_if.sv
interface dtt_det_if;
    logic              valid;
    logic              ready;
    dtt_pkg::det_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dtt_trk_if;
    logic              valid;
    logic              ready;
    dtt_pkg::trk_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dtt_cfg_if;
    logic              valid;
    logic              ready;
    dtt_pkg::cfg_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dtt_dist.sv
// shared distance unit: registered |a-b|^2 sum compared to r^2
module dtt_dist (
    input  logic                       clk,
    input  logic [dtt_pkg::CoordW-1:0] ax,
    input  logic [dtt_pkg::CoordW-1:0] ay,
    input  logic [dtt_pkg::CoordW-1:0] bx,
    input  logic [dtt_pkg::CoordW-1:0] by,
    input  logic [dtt_pkg::CoordW-1:0] radius,
    output logic                       near
);
    import dtt_pkg::*;

    logic [CoordW-1:0]   dx, dy;
    logic [2*CoordW-1:0] sqx_reg, sqy_reg, sqr_reg;

    assign dx = (ax > bx) ? ax - bx : bx - ax;
    assign dy = (ay > by) ? ay - by : by - ay;

    always_ff @(posedge clk)
    begin
        sqx_reg <= dx * dx;
        sqy_reg <= dy * dy;
        sqr_reg <= radius * radius;
    end

    assign near = ({1'b0, sqx_reg} + {1'b0, sqy_reg}) < {1'b0, sqr_reg};
endmodule

FILE: hw/rtl/detection_track_table_unit.sv
// Detection track table. Detections of one frame stream in, one beat each, at one
// cycle per beat. The beat with end_of_frame starts the frame update, run on one
// shared distance unit, followed by one result beat per track (one beat when the
// table is empty). No input is taken during the update and emission.
module detection_track_table_unit (
    input  logic   clk,
    input  logic   rst_n,
    dtt_det_if.sink   det,
    dtt_trk_if.source trk,
    dtt_cfg_if.sink   cfg
);
    import dtt_pkg::*;

    state_t state_reg, state_next;

    logic [CoordW-1:0] dedup_reg, match_reg;
    logic [CoordW-1:0] fx_reg [MaxDet];
    logic [CoordW-1:0] fy_reg [MaxDet];
    logic [MaxDet-1:0] keep_reg, keep_next, matched_reg, matched_next;
    logic [DetCntW-1:0] fcnt_reg, fcnt_next;
    logic over_reg, over_next;

    logic [MaxTrk-1:0] ev_reg;
    logic [CoordW-1:0] ex_reg [MaxTrk];
    logic [CoordW-1:0] ey_reg [MaxTrk];
    logic [WinLen-1:0] ew_reg [MaxTrk];
    logic [IdentW-1:0] eid_reg [MaxTrk];
    logic [IdentW-1:0] idc_reg, idc_next;

    logic [DetCntW-1:0] i_reg, i_next, j_reg, j_next;
    logic [TrkCntW-1:0] t_reg, t_next, w_reg, w_next;
    logic phase_reg, phase_next, seen_reg, seen_next;

    logic [CoordW-1:0] ax, ay, bx, by, rad;
    logic near;

    dtt_dist u_dist (
        .clk(clk), .ax(ax), .ay(ay), .bx(bx), .by(by), .radius(rad), .near(near)
    );

    logic [DetIdxW-1:0] ii, jj;
    logic [TrkIdxW-1:0] ti, wi;
    assign ii = i_reg[DetIdxW-1:0];
    assign jj = j_reg[DetIdxW-1:0];
    assign ti = t_reg[TrkIdxW-1:0];
    assign wi = w_reg[TrkIdxW-1:0];

    logic [WinLen-1:0] shifted;
    assign shifted = {ew_reg[ti][WinLen-2:0], seen_reg};

    logic det_fire;
    assign det.ready = (state_reg == ST_IDLE);
    assign det_fire = det.valid && det.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        ax = fx_reg[ii];
        ay = fy_reg[ii];
        rad = dedup_reg;
        if (state_reg == ST_MATCH)
        begin
            ax = ex_reg[ti];
            ay = ey_reg[ti];
            rad = match_reg;
        end
        bx = fx_reg[jj];
        by = fy_reg[jj];
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        keep_next = keep_reg;
        matched_next = matched_reg;
        fcnt_next = fcnt_reg;
        over_next = over_reg;
        idc_next = idc_reg;
        i_next = i_reg;
        j_next = j_reg;
        t_next = t_reg;
        w_next = w_reg;
        phase_next = phase_reg;
        seen_next = seen_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (det_fire)
                begin
                    if (det.data.has_detection)
                    begin
                        if (fcnt_reg < DetCntW'(MaxDet))
                        begin
                            fcnt_next = fcnt_reg + 1'b1;
                            keep_next[fcnt_reg[DetIdxW-1:0]] = 1'b1;
                        end
                        else
                        begin
                            over_next = 1'b1;
                        end
                    end
                    if (det.data.end_of_frame)
                    begin
                        matched_next = '0;
                        i_next = '0;
                        j_next = DetCntW'(1);
                        phase_next = 1'b0;
                        state_next = ST_DEDUP;
                    end
                end
            end
            ST_DEDUP:
            begin
                if (i_reg >= fcnt_reg || j_reg >= fcnt_reg)
                begin
                    if (i_reg >= fcnt_reg)
                    begin
                        t_next = '0;
                        w_next = '0;
                        j_next = '0;
                        seen_next = 1'b0;
                        phase_next = 1'b0;
                        state_next = ST_MATCH;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + 2'd2;
                    end
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    if (near)
                    begin
                        keep_next[ii] = 1'b0;
                    end
                    j_next = j_reg + 1'b1;
                end
            end
            ST_MATCH:
            begin
                if (t_reg >= TrkCntW'(MaxTrk))
                begin
                    j_next = '0;
                    state_next = ST_APPEND;
                end
                else if (!ev_reg[ti])
                begin
                    t_next = t_reg + 1'b1;
                end
                else if (j_reg >= fcnt_reg)
                begin
                    state_next = ST_SHIFT;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    if (near && keep_reg[jj])
                    begin
                        seen_next = 1'b1;
                        matched_next[jj] = 1'b1;
                    end
                    j_next = j_reg + 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (shifted != '0)
                begin
                    w_next = w_reg + 1'b1;
                end
                t_next = t_reg + 1'b1;
                j_next = '0;
                seen_next = 1'b0;
                state_next = ST_MATCH;
            end
            ST_APPEND:
            begin
                if (j_reg >= fcnt_reg)
                begin
                    t_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    if (keep_reg[jj] && !matched_reg[jj])
                    begin
                        if (w_reg >= TrkCntW'(MaxTrk))
                        begin
                            over_next = 1'b1;
                        end
                        else
                        begin
                            idc_next = idc_reg + 1'b1;
                            w_next = w_reg + 1'b1;
                        end
                    end
                    j_next = j_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (trk.ready)
                begin
                    if (t_reg + 1'b1 >= w_reg)
                    begin
                        keep_next = '0;
                        fcnt_next = '0;
                        over_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        t_next = t_reg + 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dedup_reg <= DEDUP_RESET;
            match_reg <= MATCH_RESET;
            keep_reg <= '0;
            matched_reg <= '0;
            fcnt_reg <= '0;
            over_reg <= 1'b0;
            idc_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            t_reg <= '0;
            w_reg <= '0;
            phase_reg <= 1'b0;
            seen_reg <= 1'b0;
            ev_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            keep_reg <= keep_next;
            matched_reg <= matched_next;
            fcnt_reg <= fcnt_next;
            over_reg <= over_next;
            idc_reg <= idc_next;
            i_reg <= i_next;
            j_reg <= j_next;
            t_reg <= t_next;
            w_reg <= w_next;
            phase_reg <= phase_next;
            seen_reg <= seen_next;
            if (cfg.valid)
            begin
                if (cfg.data.index == REG_DEDUP)
                begin
                    dedup_reg <= cfg.data.data;
                end
                else if (cfg.data.index == REG_MATCH)
                begin
                    match_reg <= cfg.data.data;
                end
            end
            if (state_reg == ST_MATCH && t_reg >= TrkCntW'(MaxTrk))
            begin
                for (int k = 0; k < MaxTrk; k++)
                begin
                    ev_reg[k] <= (k < 32'(w_reg));
                end
            end
            if (state_reg == ST_APPEND && j_reg < fcnt_reg && keep_reg[jj]
                && !matched_reg[jj] && w_reg < TrkCntW'(MaxTrk))
            begin
                ev_reg[wi] <= 1'b1;
            end
        end
    end

    // table and frame storage
    always_ff @(posedge clk)
    begin
        if (det_fire && det.data.has_detection && fcnt_reg < DetCntW'(MaxDet))
        begin
            fx_reg[fcnt_reg[DetIdxW-1:0]] <= det.data.det_x;
            fy_reg[fcnt_reg[DetIdxW-1:0]] <= det.data.det_y;
        end
        if (state_reg == ST_SHIFT && shifted != '0)
        begin
            ex_reg[wi] <= ex_reg[ti];
            ey_reg[wi] <= ey_reg[ti];
            ew_reg[wi] <= shifted;
            eid_reg[wi] <= eid_reg[ti];
        end
        if (state_reg == ST_APPEND && j_reg < fcnt_reg && keep_reg[jj]
            && !matched_reg[jj] && w_reg < TrkCntW'(MaxTrk))
        begin
            ex_reg[wi] <= fx_reg[jj];
            ey_reg[wi] <= fy_reg[jj];
            ew_reg[wi] <= '0;
            eid_reg[wi] <= idc_reg + 1'b1;
        end
    end

    // output beat
    logic empty;
    assign empty = (w_reg == '0);
    assign trk.valid = (state_reg == ST_EMIT_WAIT);
    always_comb
    begin
        trk.data.track_valid = !empty;
        trk.data.track_ident = empty ? '0 : eid_reg[ti];
        trk.data.track_x = empty ? '0 : ex_reg[ti];
        trk.data.track_y = empty ? '0 : ey_reg[ti];
        trk.data.seen_count = empty ? '0 : sat_ones(ew_reg[ti]);
        trk.data.dropped = over_reg;
        trk.data.last_result = empty || (t_reg + 1'b1 >= w_reg);
    end
endmodule

FILE: hw/rtl/dtt_checker.sv
module dtt_checker (
    input logic clk,
    input logic rst_n,
    input logic det_ready,
    input logic trk_valid,
    input logic trk_ready,
    input logic trk_last,
    input logic trk_tvalid
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        trk_valid |-> !det_ready) else $error("input taken during emission");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        trk_valid && !trk_ready |=> trk_valid) else $error("result beat dropped");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        trk_valid && !trk_tvalid |-> trk_last) else $error("empty table not last");
    a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
        trk_valid && trk_ready && trk_last |=> det_ready) else $error("no return to idle");
endmodule

bind detection_track_table_unit dtt_checker u_dtt_checker (
    .clk(clk), .rst_n(rst_n),
    .det_ready(det.ready),
    .trk_valid(trk.valid), .trk_ready(trk.ready),
    .trk_last(trk.data.last_result), .trk_tvalid(trk.data.track_valid)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dtt_pkg::*;

    logic clk;
    logic rst_n;
    bit   calm;

    dtt_det_if det_ch ();
    dtt_trk_if trk_ch ();
    dtt_cfg_if cfg_ch ();

    detection_track_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .det   (det_ch.sink),
        .trk   (trk_ch.source),
        .cfg   (cfg_ch.sink)
    );

    int errors;

    task automatic report(input string what, input trk_beat_t got, input trk_beat_t want);
        errors++;
        $display("mismatch %s: got %p want %p", what, got, want);
    endtask

    // Tracker predictor: frame buffer, track table and queue of expected track beats.
    class track_board;
        logic [CoordW-1:0] dedup_r = DEDUP_RESET;
        logic [CoordW-1:0] match_r = MATCH_RESET;
        logic [CoordW-1:0] fx [MaxDet];
        logic [CoordW-1:0] fy [MaxDet];
        int                fcount;
        bit                fover;
        bit                tv [MaxTrk];
        logic [CoordW-1:0] tx [MaxTrk];
        logic [CoordW-1:0] ty [MaxTrk];
        logic [WinLen-1:0] twin [MaxTrk];
        logic [IdentW-1:0] tid [MaxTrk];
        logic [IdentW-1:0] id_ctr = '0;
        trk_beat_t         pending [$];

        function bit close(logic [CoordW-1:0] ax, logic [CoordW-1:0] ay,
                           logic [CoordW-1:0] bx, logic [CoordW-1:0] by,
                           logic [CoordW-1:0] r);
            longint dx, dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            return dx * dx + dy * dy < longint'(r) * longint'(r);
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] v);
            if (idx == REG_DEDUP) dedup_r = v;
            else if (idx == REG_MATCH) match_r = v;
        endfunction

        function void note_beat(det_beat_t b);
            bit keep [MaxDet];
            bit hit [MaxDet];
            bit seen;
            int w, n;
            trk_beat_t r;
            if (b.has_detection) begin
                if (fcount < MaxDet) begin
                    fx[fcount] = b.det_x;
                    fy[fcount] = b.det_y;
                    fcount++;
                end else fover = 1;
            end
            if (!b.end_of_frame) return;
            for (int i = 0; i < fcount; i++) begin
                keep[i] = 1;
                hit[i] = 0;
                for (int j = i + 1; j < fcount; j++)
                    if (close(fx[i], fy[i], fx[j], fy[j], dedup_r)) keep[i] = 0;
            end
            w = 0;
            for (int i = 0; i < MaxTrk; i++) begin
                if (!tv[i]) continue;
                seen = 0;
                for (int j = 0; j < fcount; j++)
                    if (keep[j] && close(tx[i], ty[i], fx[j], fy[j], match_r)) begin
                        seen = 1;
                        hit[j] = 1;
                    end
                twin[i] = {twin[i][WinLen-2:0], seen};
                if (twin[i] == '0) continue;
                tx[w] = tx[i]; ty[w] = ty[i]; twin[w] = twin[i]; tid[w] = tid[i];
                tv[w] = 1;
                w++;
            end
            for (int i = w; i < MaxTrk; i++) tv[i] = 0;
            for (int j = 0; j < fcount; j++) begin
                if (!keep[j] || hit[j]) continue;
                if (w >= MaxTrk) begin
                    fover = 1;
                    continue;
                end
                id_ctr++;
                tx[w] = fx[j]; ty[w] = fy[j]; twin[w] = '0; tid[w] = id_ctr; tv[w] = 1;
                w++;
            end
            for (int i = 0; i < w; i++) begin
                n = $countones(twin[i]);
                r.track_valid = 1;
                r.track_ident = tid[i];
                r.track_x = tx[i];
                r.track_y = ty[i];
                r.seen_count = n > 31 ? 5'd31 : SeenW'(n);
                r.dropped = fover;
                r.last_result = (i + 1 == w);
                pending = {pending, r};
            end
            if (w == 0) begin
                r = '0;
                r.dropped = fover;
                r.last_result = 1;
                pending = {pending, r};
            end
            fcount = 0;
            fover = 0;
        endfunction

        task check_beat(trk_beat_t got);
            trk_beat_t want;
            if (pending.size() == 0) begin
                report("unexpected beat", got, '0);
                return;
            end
            want = pending.pop_front();
            if (got.track_valid !== want.track_valid) report("track_valid", got, want);
            if (got.track_ident !== want.track_ident) report("track_ident", got, want);
            if (got.track_x !== want.track_x) report("track_x", got, want);
            if (got.track_y !== want.track_y) report("track_y", got, want);
            if (got.seen_count !== want.seen_count) report("seen_count", got, want);
            if (got.dropped !== want.dropped) report("dropped", got, want);
            if (got.last_result !== want.last_result) report("last_result", got, want);
        endtask
    endclass

    track_board board = new();

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // sink side with random stall bursts
    initial begin
        int hold;
        trk_ch.ready <= 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (trk_ch.valid && trk_ch.ready) board.check_beat(trk_ch.data);
            if (hold > 0) begin
                hold--;
                trk_ch.ready <= 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 11);
                trk_ch.ready <= 0;
            end else trk_ch.ready <= 1;
        end
    end

    // valid stays high between back-to-back beats; gaps and drain drop it
    task automatic send_det(input det_beat_t b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            det_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        det_ch.valid <= 1;
        det_ch.data  <= b;
        do @(posedge clk); while (!det_ch.ready);
        board.note_beat(b);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] v);
        cfg_ch.valid <= 1;
        cfg_ch.data  <= '{index: idx, data: v};
        do @(posedge clk); while (!cfg_ch.ready);
        board.set_reg(idx, v);
        cfg_ch.valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        det_ch.valid <= 0;
        while (board.pending.size() != 0 && guard < 200_000) begin
            @(posedge clk);
            guard++;
        end
        repeat (1000) @(posedge clk);
    endtask

    task automatic send_point(input int x, input int y, input bit eof);
        send_det('{det_x: CoordW'(x), det_y: CoordW'(y), has_detection: 1, end_of_frame: eof});
    endtask

    task automatic send_empty(input bit eof);
        send_det('{det_x: CoordW'($urandom), det_y: CoordW'($urandom),
                   has_detection: 0, end_of_frame: eof});
    endtask

    // clustered frame near a set of anchors so tracks get matched
    task automatic random_frame(input int anchors [4], input int n);
        int a;
        for (int k = 0; k < n; k++) begin
            a = anchors[$urandom_range(0, 3)];
            if ($urandom_range(0, 9) == 0)
                send_point($urandom_range(0, 1023), $urandom_range(0, 1023), k == n - 1);
            else if ($urandom_range(0, 19) == 0)
                send_empty(k == n - 1);
            else
                send_point((a % 1024 + $urandom_range(0, 12)) % 1024,
                           (a / 1024 + $urandom_range(0, 12)) % 1024, k == n - 1);
        end
    endtask

    initial begin
        int anchors [4];
        int sent;
        errors = 0;
        calm = 0;
        rst_n = 0;
        det_ch.valid <= 0;
        det_ch.data  <= '0;
        cfg_ch.valid <= 0;
        cfg_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send_empty(1);
        send_point(0, 0, 0);
        send_point(1023, 1023, 0);
        send_point(1023, 0, 0);
        send_point(5, 5, 1);
        send_point(0, 0, 0);
        send_point(1023, 1023, 1);
        send_point(682, 341, 0);
        send_point(341, 682, 0);
        send_empty(1);
        for (int k = 0; k < 18; k++) send_point(k * 55, 1000 - k * 50, k == 17);
        drain();
        write_reg(REG_DEDUP, 0);
        write_reg(REG_MATCH, 1023);
        write_reg(8'd7, 10'd500);
        send_point(0, 0, 0);
        send_point(0, 0, 1);
        drain();
        write_reg(REG_MATCH, 0);
        for (int k = 0; k < 16; k++) send_point(k * 60, k * 60, 1);
        drain();
        write_reg(REG_DEDUP, 1023);
        write_reg(REG_MATCH, 10);

        // random phases
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) calm = 1;
            drain();
            write_reg(REG_DEDUP, ph == 0 ? 10'd1023 : ph == 1 ? 10'd0 : CoordW'($urandom_range(1, 40)));
            write_reg(REG_MATCH, ph == 2 ? 10'd0 : ph == 3 ? 10'd1023 : CoordW'($urandom_range(4, 30)));
            for (int a = 0; a < 4; a++) anchors[a] = $urandom_range(0, 1024 * 1024 - 1);
            for (int f = 0; f < 10; f++) begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(1, 8);
                random_frame(anchors, n);
                sent += n;
            end
        end

        drain();
        if (board.pending.size() != 0) errors++;
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_if.sv
hw/rtl/dtt_dist.sv
hw/rtl/detection_track_table_unit.sv
hw/rtl/dtt_checker.sv
bench/tb_top.sv
